[rtl/hte_pkg.sv]
// Package for the HTML text escaper: request descriptor type, entity codes
// and the entity character table. No dependencies.
package hte_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] LEAD_BYTE = 8'hC2;
    localparam logic [7:0] NBSP_TAIL = 8'hA0;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_BYTE = 3'd1,
        K_AMP  = 3'd2,
        K_NBSP = 3'd3,
        K_QUOT = 3'd4,
        K_LT   = 3'd5,
        K_GT   = 3'd6
    } kind_t;

    // one queued request: optional held C2 in front, then the body
    typedef struct packed {
        logic       prefix;
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } job_t;

    function automatic logic [2:0] kind_len(input kind_t kind);
        logic [2:0] len;
        unique case (kind)
            K_NONE:          len = 3'd0;
            K_BYTE:          len = 3'd1;
            K_AMP:           len = 3'd5;
            K_NBSP, K_QUOT:  len = 3'd6;
            K_LT, K_GT:      len = 3'd4;
            default:         len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kind_char(input kind_t kind, input logic [2:0] idx,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = CH_SEMI;
        unique case (kind)
            K_BYTE: c = data;
            K_AMP:
                case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = 8'h61; // a
                    3'd2:    c = 8'h6D; // m
                    3'd3:    c = 8'h70; // p
                    default: c = CH_SEMI;
                endcase
            K_NBSP:
                case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = 8'h6E; // n
                    3'd2:    c = 8'h62; // b
                    3'd3:    c = 8'h73; // s
                    3'd4:    c = 8'h70; // p
                    default: c = CH_SEMI;
                endcase
            K_QUOT:
                case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = 8'h71; // q
                    3'd2:    c = 8'h75; // u
                    3'd3:    c = 8'h6F; // o
                    3'd4:    c = 8'h74; // t
                    default: c = CH_SEMI;
                endcase
            K_LT:
                case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = 8'h6C; // l
                    3'd2:    c = 8'h74; // t
                    default: c = CH_SEMI;
                endcase
            K_GT:
                case (idx)
                    3'd0:    c = CH_AMP;
                    3'd1:    c = 8'h67; // g
                    3'd2:    c = 8'h74; // t
                    default: c = CH_SEMI;
                endcase
            default: c = CH_SEMI;
        endcase
        return c;
    endfunction

endpackage

[rtl/hte_front.sv]
// Front end: takes input bytes, tracks the held C2 and the mode register,
// and queues a request for each byte but a held C2. Depends on hte_pkg.
module hte_front
    import hte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       queue_full,
    output logic       in_ready,
    output logic       push,
    output job_t       push_job
);

    logic mode_reg, mode_next;
    logic held_reg, held_next;
    logic accept;
    job_t job;
    logic hold_now;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        job.prefix = held_reg && (in_byte != NBSP_TAIL);
        job.data   = in_byte;
        job.last   = in_last;
        job.kind   = K_BYTE;
        hold_now   = 1'b0;
        if (held_reg && in_byte == NBSP_TAIL)
            job.kind = K_NBSP;
        else if (in_byte == CH_AMP)
            job.kind = K_AMP;
        else if (in_byte == LEAD_BYTE)
        begin
            if (!in_last)
            begin
                job.kind = K_NONE;
                hold_now = 1'b1;
            end
        end
        else if (mode_reg && in_byte == CH_QUOTE)
            job.kind = K_QUOT;
        else if (!mode_reg && in_byte == CH_LT)
            job.kind = K_LT;
        else if (!mode_reg && in_byte == CH_GT)
            job.kind = K_GT;
    end

    assign push     = accept && (job.prefix || job.kind != K_NONE);
    assign push_job = job;

    assign mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;
    assign held_next = accept ? hold_now : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            held_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

endmodule

[rtl/hte_queue.sv]
// Small request queue between front and back end.
// Depends on hte_pkg.
module hte_queue
    import hte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QUEUE_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = QUEUE_CW'(count_reg + 1'b1);
        else if (!push && pop)
            count_next = QUEUE_CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

[rtl/hte_back.sv]
// Back end: walks each queued request one output byte per cycle unless
// the output stalls, into the output register. Depends on hte_pkg.
module hte_back
    import hte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_run_last,
    output logic       out_str_end
);

    logic [2:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       str_end_reg;

    logic [2:0] job_len;
    logic [2:0] idx;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       fire;

    assign job_len  = 3'(kind_len(head.kind) + {2'b00, head.prefix});
    assign idx      = 3'(step_reg - {2'b00, head.prefix});
    assign cur_byte = (head.prefix && step_reg == 3'd0) ? LEAD_BYTE
                                                        : kind_char(head.kind, idx, head.data);
    assign cur_last = (step_reg == 3'(job_len - 3'd1));
    assign fire     = head_valid && (!valid_reg || out_ready);
    assign pop      = fire && cur_last;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
            step_next  = cur_last ? 3'd0 : 3'(step_reg + 3'd1);
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg     <= cur_byte;
            run_last_reg <= cur_last;
            str_end_reg  <= cur_last && head.last;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_run_last = run_last_reg;
    assign out_str_end  = str_end_reg;

    a_step_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> step_reg < job_len)
        else $error("step beyond request length");
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && str_end_reg) |-> run_last_reg)
        else $error("string end without run end");
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> step_reg == 3'd0)
        else $error("step left nonzero with queue empty");

endmodule

[rtl/html_text_escaper_unit.sv]
// HTML text escaper: top level joining front end, request queue and back end.
// Depends on hte_pkg, hte_front, hte_queue, hte_back.
//
// Usage:
//   s_axis carries the string one byte per request, s_axis_tlast on its
//   final byte. m_axis carries the escaped bytes; m_axis_tlast marks the
//   last byte produced by one input byte, m_axis_tuser the last byte of the
//   whole string. A non-final C2 is held and produces nothing until the next
//   byte arrives. cfg_wr_en/cfg_wr_data write the mode bit (1 = attribute,
//   escape double quotes; 0 = text, escape angle brackets); write it only
//   while the block is idle.
//   An accepted byte goes into the request queue, then the walker puts
//   its first output byte in the output register. Throughput: one output
//   byte per cycle while m_axis_tready is high, set by the back-end walker;
//   a plain stream runs at one byte per cycle; an entity gives 4 to 7 bytes.
//   A four-entry request queue absorbs the difference; s_axis_tready drops
//   only when it is full. When m_axis_tready is low the output register
//   holds its byte and the walker stops, then the queue fills.
//   Reset clears the mode to text, drops any held C2 and empties the queue.
module html_text_escaper_unit
    import hte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // string_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // run_last
    output logic       m_axis_tuser    // [0] out_string_end
);

    logic push;
    job_t push_job;
    logic pop;
    logic full;
    logic empty;
    job_t head;

    hte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .queue_full (full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_job   (push_job)
    );

    hte_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .head    (head)
    );

    hte_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (!empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_run_last(m_axis_tlast),
        .out_str_end (m_axis_tuser)
    );

endmodule
